// File: hdl/obsm_pkg.sv
// Shared types, constants and helper functions for the overlapped block SAD means block.
package obsm_pkg;

    // Default values of the top-level parameters.
    localparam int DEF_MAX_BLOCKS     = 63;
    localparam int DEF_MAX_FRAME_SIDE = 4096;
    localparam int DEF_MAX_BLOCK_SIDE = 256;

    // Fixed field widths.
    localparam int POS_W  = 12;  // row and column position
    localparam int AD_W   = 17;  // absolute difference of two 16-bit samples
    localparam int GEO_W  = 17;  // block geometry in pixels
    localparam int BSUM_W = 32;
    localparam int FSUM_W = 40;
    localparam int CNT_W  = 24;
    localparam int MEAN_W = 24;
    localparam int IDX_W  = 6;
    localparam int DVD_W  = 48;  // dividend: sum shifted left by eight
    localparam int DVS_W  = 24;  // divisor: area or pixel count
    localparam int QDEPTH = 2;   // depth of the queue between front and back

    // Configuration register indexes.
    localparam logic [2:0] REG_BLOCK_HEIGHT = 3'd0;
    localparam logic [2:0] REG_BLOCK_WIDTH  = 3'd1;
    localparam logic [2:0] REG_OVERLAP      = 3'd2;
    localparam logic [2:0] REG_BLOCK_ROWS   = 3'd3;
    localparam logic [2:0] REG_BLOCK_COLS   = 3'd4;
    localparam logic [2:0] REG_TOP_MARGIN   = 3'd5;
    localparam logic [2:0] REG_LEFT_MARGIN  = 3'd6;

    // One classified pixel handed from the front to the back.
    typedef struct packed {
        logic [AD_W-1:0]  ad;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             fe;
    } t_item;

    // Configuration registers.
    typedef struct packed {
        logic [8:0]  block_height;
        logic [8:0]  block_width;
        logic [3:0]  overlap;
        logic [5:0]  block_rows;
        logic [5:0]  block_cols;
        logic [10:0] top_margin;
        logic [10:0] left_margin;
    } t_cfg;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_ACC,
        S_DRD,
        S_DLD,
        S_DIV,
        S_OUT
    } t_state;

    // Rounded-up 2^16/ov; a side of up to 256 times this, shifted right by 16,
    // gives the exact truncated quotient. An overlap of zero counts as one.
    function automatic logic [16:0] recip(input logic [3:0] ov);
        logic [16:0] r;
        unique case (ov)
            4'd0, 4'd1: r = 17'd65536;
            4'd2:  r = 17'd32768;
            4'd3:  r = 17'd21846;
            4'd4:  r = 17'd16384;
            4'd5:  r = 17'd13108;
            4'd6:  r = 17'd10923;
            4'd7:  r = 17'd9363;
            4'd8:  r = 17'd8192;
            4'd9:  r = 17'd7282;
            4'd10: r = 17'd6554;
            4'd11: r = 17'd5958;
            4'd12: r = 17'd5462;
            4'd13: r = 17'd5042;
            4'd14: r = 17'd4682;
            4'd15: r = 17'd4370;
            default: r = 17'd65536;
        endcase
        return r;
    endfunction

endpackage

// File: hdl/overlapped_block_sad_means.sv
// Top level of the overlapped block SAD means block: configuration registers and wiring.
//
//  Channel   Direction  Word contents
//  s         in         tdata: pixel_previous, pixel_current; tuser: line_end; tlast: frame_end
//  m         out        tdata: mean_value, block_index; tuser: is_frame_total; tlast: last
//  cfg       in         index 0..6 selects the register, data holds its value
//
// In the back end a pixel passes the idle state and then a read and an accumulate state per active block,
// since the block sum memory is read and written once per block over one port.
// At frame end each block mean and then the frame mean go through the shared bit-serial divider,
// and each result waits in the output state until the receiver has taken the previous word.
// The front end and a two-word queue keep accepting while the back end works, until the queue is full.
// Reset is synchronous and active low; no clearing pass is needed after it.
module overlapped_block_sad_means
    import obsm_pkg::*;
#(
    parameter int MAX_BLOCKS     = DEF_MAX_BLOCKS,
    parameter int MAX_FRAME_SIDE = DEF_MAX_FRAME_SIDE,
    parameter int MAX_BLOCK_SIDE = DEF_MAX_BLOCK_SIDE
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // pixel_previous[15:0], pixel_current[31:16]
    input  logic        i_s_tuser,   // line_end
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // mean_value[23:0], block_index[29:24], zero[31:30]
    output logic        o_m_tuser,   // is_frame_total
    output logic        o_m_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data
);

    t_cfg  r_cfg;
    t_item front_item, queue_item;
    logic  push, full, pop, empty;
    logic [MEAN_W-1:0] mean;
    logic [IDX_W-1:0]  idx;

    assign o_cfg_ready = 1'b1;

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.block_height <= 9'd16;
            r_cfg.block_width  <= 9'd16;
            r_cfg.overlap      <= 4'd2;
            r_cfg.block_rows   <= 6'd1;
            r_cfg.block_cols   <= 6'd1;
            r_cfg.top_margin   <= 11'd0;
            r_cfg.left_margin  <= 11'd0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_BLOCK_HEIGHT: r_cfg.block_height <= i_cfg_data[8:0];
                REG_BLOCK_WIDTH:  r_cfg.block_width  <= i_cfg_data[8:0];
                REG_OVERLAP:      r_cfg.overlap      <= i_cfg_data[3:0];
                REG_BLOCK_ROWS:   r_cfg.block_rows   <= i_cfg_data[5:0];
                REG_BLOCK_COLS:   r_cfg.block_cols   <= i_cfg_data[5:0];
                REG_TOP_MARGIN:   r_cfg.top_margin   <= i_cfg_data;
                REG_LEFT_MARGIN:  r_cfg.left_margin  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    obsm_front #(
        .MAX_FRAME_SIDE (MAX_FRAME_SIDE)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_s_tvalid),
        .o_ready          (o_s_tready),
        .i_pixel_previous (i_s_tdata[15:0]),
        .i_pixel_current  (i_s_tdata[31:16]),
        .i_line_end       (i_s_tuser),
        .i_frame_end      (i_s_tlast),
        .o_push           (push),
        .o_item           (front_item),
        .i_full           (full)
    );

    obsm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_item  (queue_item)
    );

    obsm_back #(
        .MAX_BLOCKS     (MAX_BLOCKS),
        .MAX_BLOCK_SIDE (MAX_BLOCK_SIDE)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_empty          (empty),
        .i_item           (queue_item),
        .o_pop            (pop),
        .o_valid          (o_m_tvalid),
        .i_ready          (i_m_tready),
        .o_mean_value     (mean),
        .o_block_index    (idx),
        .o_is_frame_total (o_m_tuser),
        .o_last           (o_m_tlast)
    );

    assign o_m_tdata = {2'b00, idx, mean};

endmodule

// File: hdl/obsm_front.sv
// Front end: accepts pixel pairs, forms the absolute difference and tracks the raster position.
module obsm_front
    import obsm_pkg::*;
#(
    parameter int MAX_FRAME_SIDE = DEF_MAX_FRAME_SIDE
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_pixel_previous,
    input  logic [15:0] i_pixel_current,
    input  logic        i_line_end,
    input  logic        i_frame_end,
    output logic        o_push,
    output t_item       o_item,
    input  logic        i_full
);

    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_FRAME_SIDE - 1);

    logic [POS_W-1:0] r_row, n_row;
    logic [POS_W-1:0] r_col, n_col;
    logic signed [AD_W-1:0] diff;

    // Absolute difference of the two samples.
    assign diff = AD_W'($signed(i_pixel_previous)) - AD_W'($signed(i_pixel_current));

    assign o_ready     = !i_full;
    assign o_push      = i_valid && !i_full;
    assign o_item.ad   = diff[AD_W-1] ? AD_W'(-diff) : AD_W'(diff);
    assign o_item.row  = r_row;
    assign o_item.col  = r_col;
    assign o_item.fe   = i_frame_end;

    // Next raster position after the accepted word.
    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (i_frame_end) begin
            n_row = '0;
            n_col = '0;
        end else if (i_line_end) begin
            n_col = '0;
            if (r_row < POS_MAX) n_row = r_row + 1'b1;
        end else if (r_col < POS_MAX) begin
            n_col = r_col + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (o_push) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

endmodule

// File: hdl/obsm_queue.sv
// Short queue that decouples the front end from the back end.
module obsm_queue
    import obsm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_item o_item
);

    localparam int PTR_W = $clog2(QDEPTH);

    t_item              r_mem [QDEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [PTR_W:0]     r_cnt;

    assign o_full  = (r_cnt == (PTR_W+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rd];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_item;
    end

endmodule

// File: hdl/obsm_back.sv
// Back end: per-block accumulation, frame-end divisions and the result register.
module obsm_back
    import obsm_pkg::*;
#(
    parameter int MAX_BLOCKS     = DEF_MAX_BLOCKS,
    parameter int MAX_BLOCK_SIDE = DEF_MAX_BLOCK_SIDE
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_empty,
    input  t_item             i_item,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [MEAN_W-1:0] o_mean_value,
    output logic [IDX_W-1:0]  o_block_index,
    output logic              o_is_frame_total,
    output logic              o_last
);

    localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int DCNT_W = $clog2(DVD_W + 1);

    // Derived geometry.
    logic [8:0]   side_h, side_w;
    logic [25:0]  prod_h, prod_w;
    logic [11:0]  nprod, nblk;
    logic [8:0]   r_sh, r_sw;
    logic [17:0]  area;

    assign side_h = (i_cfg.block_height > 9'(MAX_BLOCK_SIDE)) ? 9'(MAX_BLOCK_SIDE)
                                                              : i_cfg.block_height;
    assign side_w = (i_cfg.block_width > 9'(MAX_BLOCK_SIDE)) ? 9'(MAX_BLOCK_SIDE)
                                                             : i_cfg.block_width;
    assign prod_h = 26'(side_h) * 26'(recip(i_cfg.overlap));
    assign prod_w = 26'(side_w) * 26'(recip(i_cfg.overlap));
    assign nprod  = 12'(i_cfg.block_rows) * 12'(i_cfg.block_cols);
    assign nblk   = (nprod > 12'(MAX_BLOCKS)) ? 12'(MAX_BLOCKS) : nprod;
    assign area   = 18'(side_h) * 18'(side_w);

    // Origin steps registered; the user must make configuration changes only while no word is in flight, unenforced.
    always_ff @(posedge i_clk) begin
        r_sh <= prod_h[24:16];
        r_sw <= prod_w[24:16];
    end

    t_state r_state, n_state;

    t_item               r_item;
    logic [AW-1:0]       r_k;
    logic [5:0]          r_c;
    logic [GEO_W-1:0]    r_top, r_left;
    logic                r_hit;
    logic [BSUM_W-1:0]   r_rdata;
    logic [MAX_BLOCKS-1:0] r_bvalid;
    logic [BSUM_W-1:0]   mem [MAX_BLOCKS];
    logic [FSUM_W-1:0]   r_fsum;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_tot;

    logic [DVD_W-1:0]    r_dvd;
    logic [DVS_W-1:0]    r_dvs;
    logic [DVS_W:0]      r_rem;
    logic [DVD_W-1:0]    r_q;
    logic [DCNT_W-1:0]   r_dcnt;

    logic                r_ovalid;
    logic [MEAN_W-1:0]   r_omean;
    logic [IDX_W-1:0]    r_oidx;
    logic                r_otot;

    logic                last_blk;
    logic                hit;
    logic [BSUM_W-1:0]   cur_sum;
    logic [BSUM_W:0]     bsum_add;
    logic [BSUM_W-1:0]   bsum_new;
    logic [FSUM_W:0]     fsum_add;
    logic [DVS_W:0]      rem_sh;
    logic                qbit;
    logic [MEAN_W-1:0]   mean;

    assign last_blk = (12'(r_k) == nblk - 12'd1);
    assign cur_sum  = r_bvalid[r_k] ? r_rdata : '0;
    assign bsum_add = {1'b0, cur_sum} + (BSUM_W+1)'(r_item.ad);
    assign bsum_new = bsum_add[BSUM_W] ? '1 : bsum_add[BSUM_W-1:0];
    assign fsum_add = {1'b0, r_fsum} + (FSUM_W+1)'(i_item.ad);

    // Block membership of the current pixel for block r_k.
    assign hit = (GEO_W'(r_item.row) >= r_top) &&
                 (GEO_W'(r_item.row) < r_top + GEO_W'(side_h)) &&
                 (GEO_W'(r_item.col) >= r_left) &&
                 (GEO_W'(r_item.col) < r_left + GEO_W'(side_w));

    // One restoring division step.
    assign rem_sh = {r_rem[DVS_W-1:0], r_dvd[DVD_W-1]};
    assign qbit   = (rem_sh >= {1'b0, r_dvs});
    assign mean   = (r_dvs == '0) ? '0 :
                    (r_q[DVD_W-1:MEAN_W] != '0) ? '1 : r_q[MEAN_W-1:0];

    assign o_pop            = (r_state == S_IDLE) && !i_empty;
    assign o_valid          = r_ovalid;
    assign o_mean_value     = r_omean;
    assign o_block_index    = r_oidx;
    assign o_is_frame_total = r_otot;
    assign o_last           = r_otot;

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    if (nblk != '0)       n_state = S_RD;
                    else if (i_item.fe)   n_state = S_DIV;
                end
            end
            S_RD:  n_state = S_ACC;
            S_ACC: begin
                if (last_blk) n_state = r_item.fe ? S_DRD : S_IDLE;
                else          n_state = S_RD;
            end
            S_DRD: n_state = S_DLD;
            S_DLD: n_state = S_DIV;
            S_DIV: if (r_dcnt == DCNT_W'(DVD_W)) n_state = S_OUT;
            S_OUT: begin
                if (!r_ovalid || i_ready) begin
                    if (r_tot)         n_state = S_IDLE;
                    else if (last_blk) n_state = S_DIV;
                    else               n_state = S_DRD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_bvalid <= '0;
            r_fsum   <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && (!r_ovalid || i_ready)) r_ovalid <= 1'b1;
            else if (r_ovalid && i_ready)                    r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_fsum <= fsum_add[FSUM_W] ? '1 : fsum_add[FSUM_W-1:0];
                        if (r_cnt != '1) r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_ACC: if (r_hit) r_bvalid[r_k] <= 1'b1;
                S_OUT: begin
                    if ((!r_ovalid || i_ready) && r_tot) begin
                        r_bvalid <= '0;
                        r_fsum   <= '0;
                        r_cnt    <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath registers: block walk, divider and result word.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_item <= i_item;
                r_k    <= '0;
                r_c    <= '0;
                r_top  <= GEO_W'(i_cfg.top_margin);
                r_left <= GEO_W'(i_cfg.left_margin);
                // Frame with no blocks: divide the frame total directly.
                r_tot  <= (nblk == '0);
                r_dvd  <= DVD_W'(fsum_add[FSUM_W] ? {FSUM_W{1'b1}} : fsum_add[FSUM_W-1:0]) << 8;
                r_dvs  <= (r_cnt != '1) ? r_cnt + 1'b1 : r_cnt;
                r_rem  <= '0;
                r_dcnt <= '0;
            end
            S_RD: begin
                r_rdata <= mem[r_k];
                r_hit   <= hit;
            end
            S_ACC: begin
                if (last_blk) begin
                    r_k <= '0;
                end else begin
                    r_k <= r_k + 1'b1;
                    if (r_c == i_cfg.block_cols - 6'd1) begin
                        r_c    <= '0;
                        r_left <= GEO_W'(i_cfg.left_margin);
                        r_top  <= r_top + GEO_W'(r_sh);
                    end else begin
                        r_c    <= r_c + 1'b1;
                        r_left <= r_left + GEO_W'(r_sw);
                    end
                end
            end
            S_DRD: r_rdata <= mem[r_k];
            S_DLD: begin
                r_dvd  <= DVD_W'(cur_sum) << 8;
                r_dvs  <= DVS_W'(area);
                r_rem  <= '0;
                r_dcnt <= '0;
            end
            S_DIV: begin
                if (r_dcnt != DCNT_W'(DVD_W)) begin
                    r_rem  <= qbit ? rem_sh - {1'b0, r_dvs} : rem_sh;
                    r_q    <= {r_q[DVD_W-2:0], qbit};
                    r_dvd  <= {r_dvd[DVD_W-2:0], 1'b0};
                    r_dcnt <= r_dcnt + 1'b1;
                end
            end
            S_OUT: begin
                if (!r_ovalid || i_ready) begin
                    r_omean <= mean;
                    r_oidx  <= r_tot ? '0 : IDX_W'(r_k);
                    r_otot  <= r_tot;
                    if (!r_tot) begin
                        if (last_blk) begin
                            r_tot  <= 1'b1;
                            r_dvd  <= DVD_W'(r_fsum) << 8;
                            r_dvs  <= r_cnt;
                            r_rem  <= '0;
                            r_dcnt <= '0;
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    // Block sum memory; entries without a valid bit read as zero.
    always_ff @(posedge i_clk) begin
        if (r_state == S_ACC && r_hit) mem[r_k] <= bsum_new;
    end

endmodule

// File: tb/tb_overlapped_block_sad_means.sv
// Self-checking testbench for the overlapped block SAD means block.
module tb_overlapped_block_sad_means
    import obsm_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // One pixel pair word on the input stream.
    typedef struct {
        logic [15:0] prev;
        logic [15:0] cur;
        logic        le;
        logic        fe;
    } t_pixel;

    // One mean word on the output stream.
    typedef struct {
        logic [23:0] mean;
        logic [5:0]  idx;
        logic        total;
        logic        last;
    } t_mean;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata = '0;
    logic        i_s_tuser = 1'b0;
    logic        i_s_tlast = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;
    logic        o_m_tuser;
    logic        o_m_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [10:0] i_cfg_data = '0;

    overlapped_block_sad_means u_top (.*);

    always #10 i_clk = ~i_clk;

    // Pixels waiting to be sent and means waiting to arrive.
    t_pixel pixel_q[$];
    t_mean  mean_q[$];

    // Shadow copy of the registers and the accumulators.
    int unsigned sh_bh, sh_bw, sh_ov, sh_rows, sh_cols, sh_tm, sh_lm;
    int unsigned row_pos, col_pos;
    longint unsigned blk_sum[63];
    longint unsigned frm_sum, pix_cnt;

    int errors = 0;
    int n_pixels = 0, n_frames = 0, n_means = 0, n_writes = 0;
    bit burst = 0;
    bit tx_took = 0;
    int tx_gap = 0, rx_gap = 0, rx_hold_left = 0;
    bit rx_hold_req = 0;

    function automatic int gap_len();
        if ($urandom_range(0, 9) < 8)
            return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    function automatic longint unsigned mean_of(longint unsigned sum, longint unsigned div);
        longint unsigned q;
        if (div == 0) return 0;
        q = (sum << 8) / div;
        return (q > 64'hFFFFFF) ? 64'hFFFFFF : q;
    endfunction

    // Register write as seen by the shadow copy.
    function automatic void shadow_write(logic [2:0] idx, logic [10:0] d);
        case (idx)
            REG_BLOCK_HEIGHT: sh_bh = d[8:0];
            REG_BLOCK_WIDTH:  sh_bw = d[8:0];
            REG_OVERLAP:      sh_ov = d[3:0];
            REG_BLOCK_ROWS:   sh_rows = d[5:0];
            REG_BLOCK_COLS:   sh_cols = d[5:0];
            REG_TOP_MARGIN:   sh_tm = d;
            REG_LEFT_MARGIN:  sh_lm = d;
            default: ;
        endcase
    endfunction

    function automatic void clear_frame();
        row_pos = 0;
        col_pos = 0;
        foreach (blk_sum[k]) blk_sum[k] = 0;
        frm_sum = 0;
        pix_cnt = 0;
    endfunction

    // Accumulate one pixel and, at frame end, queue the expected means.
    function automatic void accumulate_pixel(t_pixel p);
        longint signed d;
        longint unsigned ad;
        int unsigned bh, bw, ov, sh, sw, n, r, c, top, left;
        t_mean m;
        d = longint'($signed(p.prev)) - longint'($signed(p.cur));
        ad = (d < 0) ? -d : d;
        bh = (sh_bh > 256) ? 256 : sh_bh;
        bw = (sh_bw > 256) ? 256 : sh_bw;
        ov = (sh_ov == 0) ? 1 : sh_ov;
        sh = bh / ov;
        sw = bw / ov;
        n = sh_rows * sh_cols;
        if (n > 63) n = 63;
        for (int k = 0; k < n; k++) begin
            r = k / sh_cols;
            c = k % sh_cols;
            top = r * sh + sh_tm;
            left = c * sw + sh_lm;
            if (row_pos >= top && row_pos < top + bh && col_pos >= left && col_pos < left + bw) begin
                blk_sum[k] += ad;
                if (blk_sum[k] > 64'hFFFF_FFFF) blk_sum[k] = 64'hFFFF_FFFF;
            end
        end
        frm_sum += ad;
        if (frm_sum > 64'hFF_FFFF_FFFF) frm_sum = 64'hFF_FFFF_FFFF;
        if (pix_cnt < 64'hFFFFFF) pix_cnt++;
        if (p.fe) begin
            for (int k = 0; k < n; k++) begin
                m.mean = 24'(mean_of(blk_sum[k], longint'(bh) * bw));
                m.idx = 6'(k);
                m.total = 0;
                m.last = 0;
                mean_q.push_back(m);
            end
            m.mean = 24'(mean_of(frm_sum, pix_cnt));
            m.idx = 0;
            m.total = 1;
            m.last = 1;
            mean_q.push_back(m);
            clear_frame();
        end else if (p.le) begin
            col_pos = 0;
            if (row_pos < 4095) row_pos++;
        end else if (col_pos < 4095) begin
            col_pos++;
        end
    endfunction

    // Sender: a word stays up until taken; gaps are drawn after each word.
    always @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            accumulate_pixel(pixel_q[0]);
            if (pixel_q[0].fe) n_frames++;
            pixel_q.pop_front();
            n_pixels++;
            tx_took = 1;
            tx_gap = burst ? 0 : gap_len();
        end
    end

    always @(negedge i_clk) begin
        if (i_s_tvalid && !tx_took) begin
            // word still waiting for the block
        end else if (tx_gap > 0) begin
            i_s_tvalid <= 1'b0;
            tx_gap--;
        end else if (i_rst_n && pixel_q.size() > 0) begin
            i_s_tvalid <= 1'b1;
            i_s_tdata <= {pixel_q[0].cur, pixel_q[0].prev};
            i_s_tuser <= pixel_q[0].le;
            i_s_tlast <= pixel_q[0].fe;
        end else begin
            i_s_tvalid <= 1'b0;
        end
        tx_took = 0;
    end

    // Receiver: random gaps, plus one long hold-off on request.
    always @(negedge i_clk) begin
        if (rx_hold_req) begin
            rx_hold_left = 3000;
            rx_hold_req = 0;
        end
        if (rx_hold_left > 0) begin
            i_m_tready <= 1'b0;
            rx_hold_left--;
        end else if (rx_gap > 0) begin
            i_m_tready <= 1'b0;
            rx_gap--;
        end else begin
            i_m_tready <= 1'b1;
            rx_gap = burst ? 0 : gap_len();
        end
    end

    // Compare each mean word with the oldest expected one.
    always @(posedge i_clk) begin
        if (o_m_tvalid && i_m_tready) begin
            n_means++;
            if (mean_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("Unexpected word: tdata=%h tuser=%b tlast=%b",
                                           o_m_tdata, o_m_tuser, o_m_tlast);
            end else begin
                if (o_m_tdata !== {2'b00, mean_q[0].idx, mean_q[0].mean} ||
                    o_m_tuser !== mean_q[0].total || o_m_tlast !== mean_q[0].last) begin
                    errors++;
                    if (errors <= 10)
                        $display("Mismatch: expected mean=%h idx=%0d total=%b last=%b, got tdata=%h tuser=%b tlast=%b",
                                 mean_q[0].mean, mean_q[0].idx, mean_q[0].total, mean_q[0].last,
                                 o_m_tdata, o_m_tuser, o_m_tlast);
                end
                mean_q.pop_front();
            end
        end
    end

    task automatic cfg_write(logic [2:0] idx, logic [10:0] d);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        shadow_write(idx, d);
        n_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic cfg_all(int bh, int bw, int ov, int rows, int cols, int tm, int lm);
        cfg_write(REG_BLOCK_HEIGHT, 11'(bh));
        cfg_write(REG_BLOCK_WIDTH, 11'(bw));
        cfg_write(REG_OVERLAP, 11'(ov));
        cfg_write(REG_BLOCK_ROWS, 11'(rows));
        cfg_write(REG_BLOCK_COLS, 11'(cols));
        cfg_write(REG_TOP_MARGIN, 11'(tm));
        cfg_write(REG_LEFT_MARGIN, 11'(lm));
    endtask

    // Everything sent, every mean back, then room for a pixel still in flight.
    task automatic wait_idle();
        wait (pixel_q.size() == 0);
        wait (mean_q.size() == 0);
        repeat (300) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Queue w*h pixels; ragged frames get line ends at random places.
    // With no_end the frame is left open for a later phase.
    task automatic add_frame(int w, int h, bit ragged, bit no_end = 0);
        t_pixel p;
        for (int i = 0; i < w * h; i++) begin
            p.prev = pick_sample();
            p.cur = ($urandom_range(0, 7) == 0) ? p.prev : pick_sample();
            p.le = ragged ? ($urandom_range(0, 3) == 0) : ((i % w) == w - 1);
            p.fe = !no_end && (i == w * h - 1);
            pixel_q.push_back(p);
        end
    endtask

    task automatic random_cfg();
        int bh, bw, rows, cols;
        bh = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 6) : $urandom_range(0, 511);
        bw = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 6) : $urandom_range(0, 511);
        rows = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(0, 63);
        cols = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(0, 63);
        cfg_all(bh, bw, $urandom_range(0, 15), rows, cols,
                ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(0, 2047),
                ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(0, 2047));
    endtask

    initial begin
        t_pixel p;
        sh_bh = 16; sh_bw = 16; sh_ov = 2; sh_rows = 1; sh_cols = 1; sh_tm = 0; sh_lm = 0;
        clear_frame();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings; extremes of the samples.
        p = '{prev: 16'h7FFF, cur: 16'h8000, le: 0, fe: 0};
        pixel_q.push_back(p);
        p = '{prev: 16'h8000, cur: 16'h7FFF, le: 1, fe: 0};
        pixel_q.push_back(p);
        add_frame(3, 2, 0);
        wait_idle();

        // Sides above the maximum and zero, overlap zero, far margins.
        cfg_all(511, 0, 0, 2, 2, 2047, 2047);
        add_frame(2, 2, 0);
        wait_idle();
        // No blocks at all.
        cfg_all(2, 2, 1, 0, 3, 0, 0);
        add_frame(2, 1, 0);
        wait_idle();
        // More blocks than fit; overlap at the top of its range.
        cfg_all(4, 4, 15, 63, 63, 0, 0);
        add_frame(3, 1, 0);
        wait_idle();
        // Settings change in the middle of a frame.
        cfg_all(2, 2, 2, 2, 2, 0, 0);
        add_frame(3, 1, 0, 1);
        wait_idle();
        cfg_all(1, 3, 8, 3, 1, 1, 0);
        add_frame(3, 1, 0);
        wait_idle();

        // Long hold-off on the receiver while frames keep coming.
        cfg_all(2, 2, 1, 8, 8, 0, 0);
        rx_hold_req = 1;
        repeat (4) add_frame(4, 3, 0);
        wait_idle();

        // Random settings and frames.
        while (n_pixels < 450) begin
            random_cfg();
            burst = ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(1, 3))
                add_frame($urandom_range(1, 10), $urandom_range(1, 6), $urandom_range(0, 5) == 0);
            wait_idle();
        end
        burst = 0;

        if (mean_q.size() != 0) errors++;
        $display("Sent %0d pixels in %0d frames under %0d register writes; checked %0d means.",
                 n_pixels, n_frames, n_writes, n_means);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #300_000_000;
        $display("Timeout with %0d pixels and %0d means outstanding.", pixel_q.size(),
                 mean_q.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
